// ----- rtl/core/cds_pkg.sv -----
// cds_pkg: payload types, request codes and calendar constants for the
// calendar date stepper. No dependencies.
package cds_pkg;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_NEXT   = 2'd1,
    REQ_PREV   = 2'd2,
    REQ_REPORT = 2'd3
  } req_code_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [4:0]  day_in;
    logic [3:0]  month_in;
    logic [15:0] year_in;
  } req_t;

  typedef struct packed {
    logic [4:0]  day_out;
    logic [3:0]  month_out;
    logic [15:0] year_out;
    logic [2:0]  weekday;
    logic        load_rejected;
  } res_t;

  localparam logic [4:0]  DEFAULT_DAY   = 5'd1;
  localparam logic [3:0]  DEFAULT_MONTH = 4'd1;
  localparam logic [15:0] DEFAULT_YEAR  = 16'd1970;
  // 1970 = 19 * 100 + 70, 19 mod 4 = 3
  localparam logic [6:0]  DEFAULT_REM   = 7'd70;
  localparam logic [1:0]  DEFAULT_CENT  = 2'd3;

  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [3:0]  MONTH_DEC = 4'd12;
  localparam logic [6:0]  REM_LAST  = 7'd99;

  // floor(y / 100) = (y * RECIP_100) >> RECIP_SHIFT, exact for 16-bit y
  localparam logic [16:0] RECIP_100   = 17'd83887;
  localparam int          RECIP_SHIFT = 23;

  function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // (26*m - 2)/10 mod 7, with m counted from March = 1
  function automatic logic [2:0] month_offset(input logic [3:0] month);
    logic [2:0] ofs;
    case (month)
      4'd1:    ofs = 3'd0;
      4'd2:    ofs = 3'd3;
      4'd3:    ofs = 3'd2;
      4'd4:    ofs = 3'd5;
      4'd5:    ofs = 3'd0;
      4'd6:    ofs = 3'd3;
      4'd7:    ofs = 3'd5;
      4'd8:    ofs = 3'd1;
      4'd9:    ofs = 3'd4;
      4'd10:   ofs = 3'd6;
      4'd11:   ofs = 3'd2;
      4'd12:   ofs = 3'd4;
      default: ofs = 3'd0;
    endcase
    return ofs;
  endfunction

  // (c/4 + 5c) mod 7 = 5 * (c mod 4) mod 7
  function automatic logic [2:0] cent_term(input logic [1:0] cmod4);
    logic [2:0] t;
    case (cmod4)
      2'd0:    t = 3'd0;
      2'd1:    t = 3'd5;
      2'd2:    t = 3'd3;
      default: t = 3'd1;
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/core/calendar_date_stepper.sv -----
// calendar_date_stepper: Gregorian date register with day stepping and weekday.
// Depends on cds_pkg.
//
// Usage:
//   Request channel req_valid / req_stall / req_data (req_t): load a date,
//   step one day forward or back, or report. A transfer happens at a clock
//   edge with valid high and stall low.
//   Result channel res_valid / res_stall / res_data (res_t): one result per
//   request, in order: date after the request, weekday (Sunday = 0) and the
//   load rejection flag. An invalid load gives 1.1.1970 with the flag set.
//   Throughput: one request per cycle while res_stall is low. Stages:
//   input register, divide-by-100 multiplier, load check, held date (the
//   only feedback loop: one day step per cycle when not stalled), weekday
//   and result register.
//   The held date also keeps year mod 100 and century mod 4, so stepping and
//   the weekday need no division.
//   Stall: a stalled result holds; stages behind it fill their empty slots
//   and req_stall rises only once every stage holds a request.
//   Reset (rst, synchronous): pipeline empties, date returns to 1.1.1970.
module calendar_date_stepper
  import cds_pkg::*;
#(
  parameter int YEAR_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req_data,
  output logic res_valid,
  input  logic res_stall,
  output res_t res_data
);

  localparam logic [15:0] LOAD_MASK = (YEAR_WIDTH >= 16) ? 16'hFFFF :
                                      16'((32'd1 << YEAR_WIDTH) - 32'd1);
  localparam logic [YEAR_WIDTH-1:0] YEAR_MAX   = '1;
  localparam logic [YEAR_WIDTH-1:0] YEAR_RESET = YEAR_WIDTH'(DEFAULT_YEAR);
  localparam logic [YEAR_WIDTH-1:0] YEAR_ONE   = YEAR_WIDTH'(1);
  localparam logic [6:0] MAX_REM  = 7'(((64'd1 << YEAR_WIDTH) - 64'd1) % 64'd100);
  localparam logic [1:0] MAX_CENT = 2'((((64'd1 << YEAR_WIDTH) - 64'd1) / 64'd100) % 64'd4);

  // stage advance chain, bubbles collapse
  logic adv_a, adv_b, adv_c, adv_d, adv_e;

  // stage A: input register
  logic a_valid;
  req_t a_req;
  req_t req_masked;
  logic [32:0] a_prod;

  // stage B: quotient by 100
  logic b_valid;
  req_t b_req;
  logic [9:0] b_quot;
  logic [15:0] b_hundreds;
  logic [6:0] b_rem;
  logic b_leap, b_ok;

  // stage C: checked load
  logic c_valid;
  req_code_t c_code;
  logic [4:0] c_day;
  logic [3:0] c_month;
  logic [YEAR_WIDTH-1:0] c_year;
  logic [6:0] c_rem;
  logic [1:0] c_cent;
  logic c_rejected;

  // stage D: held date
  logic d_valid, d_rejected;
  logic [4:0] cur_day, day_next;
  logic [3:0] cur_month, month_next;
  logic [YEAR_WIDTH-1:0] cur_year, year_next;
  logic [6:0] cur_rem, rem_next;
  logic [1:0] cur_cent, cent_next;
  logic cur_leap;
  logic [4:0] cur_len;

  // weekday
  logic early;
  logic [6:0] y_adj;
  logic [1:0] c_mod4;
  logic [7:0] wd_sum;
  logic [2:0] wd;

  logic e_valid;

  function automatic logic [2:0] mod7(input logic [7:0] s);
    logic [4:0] t;
    logic [3:0] u;
    // 8 = 1 mod 7: fold octal digits
    t = 5'(s[7:6]) + 5'(s[5:3]) + 5'(s[2:0]);
    u = 4'(t[4:3]) + 4'(t[2:0]);
    return (u >= 4'd7) ? 3'(u - 4'd7) : u[2:0];
  endfunction

  assign adv_e = !e_valid || !res_stall;
  assign adv_d = !d_valid || adv_e;
  assign adv_c = !c_valid || adv_d;
  assign adv_b = !b_valid || adv_c;
  assign adv_a = !a_valid || adv_b;
  assign req_stall = !adv_a;
  assign res_valid = e_valid;

  always_comb begin
    req_masked         = req_data;
    req_masked.year_in = req_data.year_in & LOAD_MASK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv_a) begin
      a_valid <= req_valid;
    end
    if (adv_a && req_valid) begin
      a_req <= req_masked;
    end
  end

  assign a_prod = 33'(a_req.year_in) * 33'(RECIP_100);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv_b) begin
      b_valid <= a_valid;
    end
    if (adv_b && a_valid) begin
      b_req  <= a_req;
      b_quot <= a_prod[RECIP_SHIFT +: 10];
    end
  end

  always_comb begin
    b_hundreds = 16'({b_quot, 6'b0}) + 16'({b_quot, 5'b0}) + 16'({b_quot, 2'b0});
    b_rem  = 7'(b_req.year_in - b_hundreds);
    b_leap = (b_rem[1:0] == 2'd0 && b_rem != 7'd0) || (b_rem == 7'd0 && b_quot[1:0] == 2'd0);
    b_ok   = (b_req.year_in != 16'd0) && (b_req.month_in >= 4'd1) &&
             (b_req.month_in <= MONTH_DEC) && (b_req.day_in != 5'd0) &&
             (b_req.day_in <= days_in_month(b_req.month_in, b_leap));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv_c) begin
      c_valid <= b_valid;
    end
    if (adv_c && b_valid) begin
      c_code     <= req_code_t'(b_req.req_type);
      c_rejected <= !b_ok;
      if (b_ok) begin
        c_day   <= b_req.day_in;
        c_month <= b_req.month_in;
        c_year  <= YEAR_WIDTH'(b_req.year_in);
        c_rem   <= b_rem;
        c_cent  <= b_quot[1:0];
      end else begin
        c_day   <= DEFAULT_DAY;
        c_month <= DEFAULT_MONTH;
        c_year  <= YEAR_RESET;
        c_rem   <= DEFAULT_REM;
        c_cent  <= DEFAULT_CENT;
      end
    end
  end

  // day step or load on the held date
  always_comb begin
    cur_leap   = (cur_rem[1:0] == 2'd0 && cur_rem != 7'd0) ||
                 (cur_rem == 7'd0 && cur_cent == 2'd0);
    cur_len    = days_in_month(cur_month, cur_leap);
    day_next   = cur_day;
    month_next = cur_month;
    year_next  = cur_year;
    rem_next   = cur_rem;
    cent_next  = cur_cent;
    case (c_code)
      REQ_LOAD: begin
        day_next   = c_day;
        month_next = c_month;
        year_next  = c_year;
        rem_next   = c_rem;
        cent_next  = c_cent;
      end
      REQ_NEXT: begin
        if (cur_day >= cur_len) begin
          day_next = 5'd1;
          if (cur_month == MONTH_DEC) begin
            month_next = 4'd1;
            year_next  = cur_year + YEAR_ONE;
            if (cur_year == YEAR_MAX) begin
              rem_next  = 7'd0;
              cent_next = 2'd0;
            end else if (cur_rem == REM_LAST) begin
              rem_next  = 7'd0;
              cent_next = cur_cent + 2'd1;
            end else begin
              rem_next = cur_rem + 7'd1;
            end
          end else begin
            month_next = cur_month + 4'd1;
          end
        end else begin
          day_next = cur_day + 5'd1;
        end
      end
      REQ_PREV: begin
        if (cur_day <= 5'd1) begin
          if (cur_month <= 4'd1) begin
            month_next = MONTH_DEC;
            day_next   = 5'd31;
            year_next  = cur_year - YEAR_ONE;
            if (cur_year == '0) begin
              rem_next  = MAX_REM;
              cent_next = MAX_CENT;
            end else if (cur_rem == 7'd0) begin
              rem_next  = REM_LAST;
              cent_next = cur_cent - 2'd1;
            end else begin
              rem_next = cur_rem - 7'd1;
            end
          end else begin
            month_next = cur_month - 4'd1;
            day_next   = days_in_month(cur_month - 4'd1, cur_leap);
          end
        end else begin
          day_next = cur_day - 5'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid    <= 1'b0;
      d_rejected <= 1'b0;
      cur_day    <= DEFAULT_DAY;
      cur_month  <= DEFAULT_MONTH;
      cur_year   <= YEAR_RESET;
      cur_rem    <= DEFAULT_REM;
      cur_cent   <= DEFAULT_CENT;
    end else if (adv_d) begin
      d_valid <= c_valid;
      if (c_valid) begin
        d_rejected <= (c_code == REQ_LOAD) && c_rejected;
        cur_day    <= day_next;
        cur_month  <= month_next;
        cur_year   <= year_next;
        cur_rem    <= rem_next;
        cur_cent   <= cent_next;
      end
    end
  end

  // Zeller on year + 400; Jan/Feb count as months of the year before
  always_comb begin
    early  = cur_month <= MONTH_FEB;
    y_adj  = cur_rem;
    c_mod4 = cur_cent;
    if (early) begin
      if (cur_rem == 7'd0) begin
        y_adj  = REM_LAST;
        c_mod4 = cur_cent - 2'd1;
      end else begin
        y_adj = cur_rem - 7'd1;
      end
    end
    wd_sum = 8'(cur_day) + 8'(month_offset(cur_month)) + 8'(y_adj) +
             8'(y_adj >> 2) + 8'(cent_term(c_mod4));
    wd = mod7(wd_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv_e) begin
      e_valid <= d_valid;
    end
    if (adv_e && d_valid) begin
      res_data.day_out       <= cur_day;
      res_data.month_out     <= cur_month;
      res_data.year_out      <= 16'(cur_year);
      res_data.weekday       <= wd;
      res_data.load_rejected <= d_rejected;
    end
  end

endmodule

// ----- rtl/core/cds_checker.sv -----
// cds_checker: port-level assertions for calendar_date_stepper, bound to the top.
// Depends on cds_pkg.
module cds_checker
  import cds_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_stall,
  input res_t res_data
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("stalled result changed");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data.day_out != 5'd0 && res_data.month_out >= 4'd1 &&
                  res_data.month_out <= MONTH_DEC && res_data.weekday <= 3'd6)
    else $error("result date or weekday out of range");

  a_reject_default: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.load_rejected |->
      res_data.day_out == DEFAULT_DAY && res_data.month_out == DEFAULT_MONTH &&
      res_data.year_out == DEFAULT_YEAR)
    else $error("rejected load did not give the default date");

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

endmodule

bind calendar_date_stepper cds_checker u_cds_checker (
  .clk(clk),
  .rst(rst),
  .res_valid(res_valid),
  .res_stall(res_stall),
  .res_data(res_data)
);
